// ----- rtl/m44i_pkg.sv -----
package m44i_pkg;

  localparam int EL_W          = 32;   // element and result field width
  localparam int ROW_W         = 2;
  localparam int DIG_W         = 8;    // multiplier digit width
  localparam int NDIG          = EL_W / DIG_W;
  localparam int DIG_CNT_W     = $clog2(NDIG);
  localparam int AW            = 132;  // exact width of minors, cofactors and determinant
  localparam int NTMP          = 28;   // 12 minors + 16 cofactors
  localparam int TMP_W         = 5;
  localparam int NOPS          = 76;   // 24 minor, 48 cofactor, 4 determinant terms
  localparam int OP_W          = 7;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [TMP_W-1:0] DST_DET  = 5'd28;
  localparam logic [TMP_W-1:0] COF_BASE = 5'd12;

  typedef struct packed {
    logic [3:0]       a_addr;  // element address row*4+col
    logic             b_is_el; // second operand is an element
    logic [TMP_W-1:0] b_idx;   // element address or temp index
    logic             sub;     // subtract this term
    logic             first;   // clear accumulator
    logic             last;    // write accumulator to dst
    logic [TMP_W-1:0] dst;
  } op_t;

  function automatic int pair_c1(input int p);
    int r;
    r = (p < 3) ? 0 : ((p < 5) ? 1 : 2);
    return r;
  endfunction

  function automatic int pair_c2(input int p);
    int r;
    unique case (p)
      0: r = 1;
      1: r = 2;
      2: r = 3;
      3: r = 2;
      4: r = 3;
      default: r = 3;
    endcase
    return r;
  endfunction

  function automatic int pair_idx(input int x, input int y);
    int r;
    r = (x == 0) ? (y - 1) : ((x == 1) ? (y + 1) : 5);
    return r;
  endfunction

  // Microcode: one multiply-accumulate term per entry.
  function automatic op_t op_decode(input logic [OP_W-1:0] idx);
    op_t o;
    int  k, m, t, ra, rb, c1, c2, ci, p, i, j, r, base, cc0, cc1, cc2, col, x, y, n;
    o = '0;
    k = int'(idx);
    if (k < 24) begin
      m  = k / 2;
      t  = k % 2;
      ra = (m < 6) ? 2 : 0;
      rb = ra + 1;
      c1 = pair_c1((m < 6) ? m : m - 6);
      c2 = pair_c2((m < 6) ? m : m - 6);
      o.b_is_el = 1'b1;
      if (t == 0) begin
        o.a_addr = 4'(4 * ra + c1);
        o.b_idx  = 5'(4 * rb + c2);
        o.sub    = 1'b0;
      end else begin
        o.a_addr = 4'(4 * ra + c2);
        o.b_idx  = 5'(4 * rb + c1);
        o.sub    = 1'b1;
      end
      o.first = (t == 0);
      o.last  = (t == 1);
      o.dst   = 5'(m);
    end else if (k < 72) begin
      ci = 0;
      for (n = 1; n < 16; n++) begin
        if (k - 24 >= 3 * n) ci = n;
      end
      p    = k - 24 - 3 * ci;
      i    = ci / 4;
      j    = ci % 4;
      cc0  = (j == 0) ? 1 : 0;
      cc1  = (j <= 1) ? 2 : 1;
      cc2  = (j <= 2) ? 3 : 2;
      r    = i ^ 1;
      base = (i < 2) ? 0 : 6;
      if (p == 0) begin
        col = cc0; x = cc1; y = cc2;
      end else if (p == 1) begin
        col = cc1; x = cc0; y = cc2;
      end else begin
        col = cc2; x = cc0; y = cc1;
      end
      o.a_addr  = 4'(4 * r + col);
      o.b_is_el = 1'b0;
      o.b_idx   = 5'(base + pair_idx(x, y));
      o.sub     = (p == 1) ^ (((i + j) % 2) == 1);
      o.first   = (p == 0);
      o.last    = (p == 2);
      o.dst     = 5'(12 + ci);
    end else begin
      j = k - 72;
      o.a_addr  = 4'(j);
      o.b_is_el = 1'b0;
      o.b_idx   = 5'(12 + j);
      o.sub     = 1'b0;
      o.first   = (j == 0);
      o.last    = (j == 3);
      o.dst     = DST_DET;
    end
    return o;
  endfunction

endpackage

// ----- rtl/m44i_if.sv -----
interface m44i_in_if;
  import m44i_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        row_index;
  logic signed [EL_W-1:0]  elem_c0;
  logic signed [EL_W-1:0]  elem_c1;
  logic signed [EL_W-1:0]  elem_c2;
  logic signed [EL_W-1:0]  elem_c3;
  modport source (output valid, row_index, elem_c0, elem_c1, elem_c2, elem_c3,
                  input ready);
  modport sink (input valid, row_index, elem_c0, elem_c1, elem_c2, elem_c3,
                output ready);
endinterface

interface m44i_out_if;
  import m44i_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        out_row;
  logic signed [EL_W-1:0]  res_c0;
  logic signed [EL_W-1:0]  res_c1;
  logic signed [EL_W-1:0]  res_c2;
  logic signed [EL_W-1:0]  res_c3;
  logic                    singular;
  logic                    last_row;
  modport source (output valid, out_row, res_c0, res_c1, res_c2, res_c3, singular,
                  last_row, input ready);
  modport sink (input valid, out_row, res_c0, res_c1, res_c2, res_c3, singular,
                last_row, output ready);
endinterface

// ----- rtl/m44i_div.sv -----
module m44i_div #(
  parameter int FRAC_BITS = m44i_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = m44i_pkg::WORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [m44i_pkg::AW-1:0]     num,
  input  logic signed [m44i_pkg::AW-1:0]     den,
  output logic                               done,
  output logic [m44i_pkg::EL_W-1:0]          quo
);
  import m44i_pkg::*;

  localparam int SH_W  = (2 * FRAC_BITS > WORD_BITS + 1) ? 2 * FRAC_BITS : WORD_BITS + 1;
  localparam int CW    = AW + SH_W;
  localparam int QW    = WORD_BITS + 2;
  localparam int CNT_W = $clog2(QW + 1);
  localparam int XW    = QW + EL_W;
  localparam logic [QW-1:0] LIM = {{(QW-1){1'b0}}, 1'b1} << (WORD_BITS - 1);

  logic [CW-1:0]    rem_r, dv_r;
  logic [QW-1:0]    q_r;
  logic             neg_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [AW-1:0]    nmag, dmag;
  logic             ge;
  logic [QW-1:0]    mag;
  logic [XW-1:0]    sval;

  assign nmag = num[AW-1] ? AW'(-num) : AW'(num);
  assign dmag = den[AW-1] ? AW'(-den) : AW'(den);
  assign ge   = (rem_r >= dv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(QW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) done_r <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle from bit WORD_BITS+1 down
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CW'(nmag) << (2 * FRAC_BITS);
      dv_r  <= CW'(dmag) << (WORD_BITS + 1);
      neg_r <= num[AW-1] ^ den[AW-1];
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      if (ge) rem_r <= rem_r - dv_r;
      dv_r <= dv_r >> 1;
      q_r  <= {q_r[QW-2:0], ge};
    end
  end

  always_comb begin
    if (neg_r) mag = (q_r > LIM) ? LIM : q_r;
    else       mag = (q_r > LIM - 1'b1) ? LIM - 1'b1 : q_r;
    sval = neg_r ? XW'(-{{EL_W{1'b0}}, mag}) : {{EL_W{1'b0}}, mag};
  end

  assign done = done_r;
  assign quo  = sval[EL_W-1:0];

endmodule

// ----- rtl/matrix4x4_inverse.sv -----
// 4x4 matrix inverse, signed fixed point (Q16.16 by default).
// in_bus: one matrix row per beat (row_index, elem_c0..elem_c3). Rows 0..2
//   are only stored. Row 3 is stored and starts the inversion;
//   in_bus.ready stays low until all four result rows are taken.
// out_bus: four beats, inverse rows 0..3, last_row set on row 3. singular
//   is set, with zero elements, when the determinant is zero.
// After row 3: the shared 132x8 multiply-accumulate unit runs 76 terms
//   (minors, cofactors, determinant). The bit-serial divider then works
//   one result row at a time: each of its four elements gets a start step
//   and WORD_BITS+2 quotient bits before the quotient is taken, and the
//   row is then offered on out_bus.
// Reset: clears the row store to zero (by per-row valid bits) and the
//   sequencer; rows never sent read as zero. The store is kept across
//   inversions.
// A stalled receiver holds the current result row in its output register;
//   the sequencer waits and no new input is taken.
module matrix4x4_inverse #(
  parameter int FRAC_BITS = m44i_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = m44i_pkg::WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  m44i_in_if.sink    in_bus,
  m44i_out_if.source out_bus
);
  import m44i_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LD0  = 3'd1;
  localparam logic [2:0] S_LD1  = 3'd2;
  localparam logic [2:0] S_LD2  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DST  = 3'd5;
  localparam logic [2:0] S_DWT  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]              state_r;
  logic [4*EL_W-1:0]       mem [4];
  logic [3:0]              vld_r;
  logic [4*EL_W-1:0]       rd_r;
  logic                    rdv_r;
  logic [ROW_W-1:0]        rd_addr;
  logic [1:0]              el_col;
  logic signed [EL_W-1:0]  el_val;

  logic [OP_W-1:0]         op_idx_r;
  op_t                     op;
  logic signed [EL_W-1:0]  a_r;
  logic signed [AW-1:0]    bs_r, acc_r, acc_nxt, acc_base, bsrc, term;
  logic [DIG_CNT_W-1:0]    dig_r;
  logic [DIG_W-1:0]        dig;
  logic signed [DIG_W:0]   dsig;
  logic signed [AW+DIG_W:0] pp;

  logic signed [AW-1:0]    tmp_r [NTMP];
  logic signed [AW-1:0]    det_r;
  logic [TMP_W-1:0]        tmp_ra;
  logic signed [AW-1:0]    tmp_rd;

  logic [1:0]              col_r;
  logic [ROW_W-1:0]        orow_r;
  logic [EL_W-1:0]         res_r [4];
  logic                    sing_r;
  logic                    in_acc;
  logic                    div_start, div_done;
  logic [EL_W-1:0]         div_quo;

  assign op     = op_decode(op_idx_r);
  assign in_acc = in_bus.valid && in_bus.ready;

  // row store: one row per entry, registered read
  assign rd_addr = (state_r == S_LD0) ? op.a_addr[3:2] : op.b_idx[3:2];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[in_bus.row_index] <= {in_bus.elem_c3, in_bus.elem_c2, in_bus.elem_c1,
                                in_bus.elem_c0};
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rdv_r <= 1'b0;
    end else begin
      if (in_acc) vld_r[in_bus.row_index] <= 1'b1;
      rdv_r <= vld_r[rd_addr];
    end
  end

  assign el_col = (state_r == S_LD1) ? op.a_addr[1:0] : op.b_idx[1:0];
  assign el_val = rdv_r ? rd_r[el_col*EL_W +: EL_W] : '0;

  // temp file: one read port shared by operand load and divider start
  assign tmp_ra = (state_r == S_LD2) ? op.b_idx : (COF_BASE + {1'b0, col_r, orow_r});
  assign tmp_rd = tmp_r[tmp_ra];

  assign bsrc = op.b_is_el ? {{(AW-EL_W){el_val[EL_W-1]}}, el_val} : tmp_rd;

  // multiply-accumulate: one 8-bit digit of the element per cycle
  always_comb begin
    dig      = a_r[dig_r*DIG_W +: DIG_W];
    dsig     = (dig_r == DIG_CNT_W'(NDIG-1)) ? {dig[DIG_W-1], dig} : {1'b0, dig};
    pp       = bs_r * dsig;
    term     = pp[AW-1:0] << {dig_r, 3'b000};
    acc_base = (op.first && dig_r == '0) ? '0 : acc_r;
    acc_nxt  = acc_base + term;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LD1) a_r <= el_val;
    if (state_r == S_LD2) bs_r <= op.sub ? AW'(-bsrc) : bsrc;
    if (state_r == S_MUL) begin
      acc_r <= acc_nxt;
      if (dig_r == DIG_CNT_W'(NDIG-1) && op.last) begin
        if (op.dst == DST_DET) det_r <= acc_nxt;
        else                   tmp_r[op.dst] <= acc_nxt;
      end
    end
    if (state_r == S_DST) begin
      sing_r <= (det_r == '0);
      if (det_r == '0) begin
        for (int k = 0; k < 4; k++) res_r[k] <= '0;
      end
    end
    if (state_r == S_DWT && div_done) res_r[col_r] <= div_quo;
  end

  assign div_start = (state_r == S_DST) && (det_r != '0);

  m44i_div #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (tmp_rd),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      op_idx_r <= '0;
      dig_r    <= '0;
      col_r    <= '0;
      orow_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_bus.row_index == ROW_W'(3)) begin
            op_idx_r <= '0;
            state_r  <= S_LD0;
          end
        end
        S_LD0: state_r <= S_LD1;
        S_LD1: state_r <= S_LD2;
        S_LD2: begin
          dig_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          dig_r <= dig_r + 1'b1;
          if (dig_r == DIG_CNT_W'(NDIG-1)) begin
            if (op_idx_r == OP_W'(NOPS-1)) begin
              col_r   <= '0;
              orow_r  <= '0;
              state_r <= S_DST;
            end else begin
              op_idx_r <= op_idx_r + 1'b1;
              state_r  <= S_LD0;
            end
          end
        end
        S_DST: begin
          // singular: skip the divider, results are already zero
          state_r <= (det_r == '0) ? S_OUT : S_DWT;
        end
        S_DWT: begin
          if (div_done) begin
            col_r <= col_r + 1'b1;
            state_r <= (col_r == 2'd3) ? S_OUT : S_DST;
          end
        end
        S_OUT: begin
          if (out_bus.ready) begin
            col_r <= '0;
            if (orow_r == ROW_W'(3)) begin
              state_r <= S_IDLE;
            end else begin
              orow_r  <= orow_r + 1'b1;
              state_r <= S_DST;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_bus.ready     = (state_r == S_IDLE);
  assign out_bus.valid    = (state_r == S_OUT);
  assign out_bus.out_row  = orow_r;
  assign out_bus.res_c0   = res_r[0];
  assign out_bus.res_c1   = res_r[1];
  assign out_bus.res_c2   = res_r[2];
  assign out_bus.res_c3   = res_r[3];
  assign out_bus.singular = sing_r;
  assign out_bus.last_row = (orow_r == ROW_W'(3));

`ifndef ASSERT_OFF
  // taking the last result row frees the input side
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.ready && out_bus.last_row |=> in_bus.ready)
    else $error("input not ready after last result row");

  // a singular result carries only zero elements
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.singular |->
      out_bus.res_c0 == '0 && out_bus.res_c1 == '0 &&
      out_bus.res_c2 == '0 && out_bus.res_c3 == '0)
    else $error("singular row with nonzero element");

  // the divider reports only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DWT)
    else $error("divider done outside wait state");
`endif

endmodule

// ----- tb/matrix4x4_inverse_tb.sv -----
`default_nettype none

module matrix4x4_inverse_tb;
  import m44i_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 20000;  // far above one inversion plus the long hold-off
  localparam int LONG_HOLD   = 2500;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [ROW_W-1:0]           row;
    logic [3:0][EL_W-1:0]       el;
  } row_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]           row;
    logic [3:0][EL_W-1:0]       res;
    logic                       singular;
    logic                       last;
  } inv_row_t;

  logic clk;
  logic rst_n;

  m44i_in_if  in_bus ();
  m44i_out_if out_bus ();

  matrix4x4_inverse i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Shadow copy of the row store and the queues that feed and check the block.
  logic [EL_W-1:0] shadow_store [16];
  row_beat_t       pending_rows [$];
  inv_row_t        inverse_rows [$];

  int rows_accepted;
  int results_taken;
  int singular_taken;
  int mismatches;
  int idle_cycles;
  int burst_left;
  int gap_left;
  int hold_left;
  bit hold_done;
  logic [6:0] stall_phase;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // trunc(cofactor * 2^(2*FRAC) / det), clamped to the signed 32-bit range
  function automatic logic [EL_W-1:0] scaled_quotient(input wide_t cof, input wide_t det);
    wide_t q;
    q = (cof <<< (2 * FRAC_BITS_DEF)) / det;
    if (q > $signed(256'h7FFF_FFFF)) q = $signed(256'h7FFF_FFFF);
    if (q < -$signed(256'h8000_0000)) q = -$signed(256'h8000_0000);
    return q[EL_W-1:0];
  endfunction

  // Store the row; on row 3 invert the whole store and queue the four result rows.
  function automatic void absorb_row(input row_beat_t b);
    wide_t   el [4][4];
    wide_t   cof [4][4];
    wide_t   det;
    int      rr [3];
    int      cc [3];
    int      n;
    bit      sing;
    inv_row_t o;
    for (int c = 0; c < 4; c++) shadow_store[b.row * 4 + c] = b.el[c];
    if (b.row != 2'd3) return;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) el[i][j] = $signed(shadow_store[i * 4 + j]);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        n = 0;
        for (int k = 0; k < 4; k++) if (k != i) begin rr[n] = k; n++; end
        n = 0;
        for (int k = 0; k < 4; k++) if (k != j) begin cc[n] = k; n++; end
        cof[i][j] =
            el[rr[0]][cc[0]] * (el[rr[1]][cc[1]] * el[rr[2]][cc[2]]
                              - el[rr[1]][cc[2]] * el[rr[2]][cc[1]])
          - el[rr[0]][cc[1]] * (el[rr[1]][cc[0]] * el[rr[2]][cc[2]]
                              - el[rr[1]][cc[2]] * el[rr[2]][cc[0]])
          + el[rr[0]][cc[2]] * (el[rr[1]][cc[0]] * el[rr[2]][cc[1]]
                              - el[rr[1]][cc[1]] * el[rr[2]][cc[0]]);
        if (((i + j) % 2) == 1) cof[i][j] = -cof[i][j];
      end
    end
    det = '0;
    for (int j = 0; j < 4; j++) det = det + el[0][j] * cof[0][j];
    sing = (det == '0);
    for (int r = 0; r < 4; r++) begin
      o.row      = ROW_W'(r);
      o.singular = sing;
      o.last     = (r == 3);
      // inverse is the transposed cofactor matrix over det
      for (int c = 0; c < 4; c++) o.res[c] = sing ? '0 : scaled_quotient(cof[c][r], det);
      inverse_rows.push_back(o);
    end
  endfunction

  function automatic logic [EL_W-1:0] pick_elem(input int kind);
    logic [EL_W-1:0] v;
    case (kind)
      0: v = EL_W'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;   // within +-4.0
      1: v = $urandom();
      default: begin
        case ($urandom_range(0, 5))
          0: v = 32'h0;
          1: v = 32'h1;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          4: v = 32'h8000_0000;
          default: v = 32'h0001_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic void queue_row(input int row, input logic [EL_W-1:0] a,
                                    input logic [EL_W-1:0] b, input logic [EL_W-1:0] c,
                                    input logic [EL_W-1:0] d);
    row_beat_t r;
    r.row = ROW_W'(row);
    r.el  = {d, c, b, a};
    pending_rows.push_back(r);
  endfunction

  // Diagonal matrix helper, rows sent in order 0 to 3.
  function automatic void queue_diag(input logic [EL_W-1:0] d0, input logic [EL_W-1:0] d1,
                                     input logic [EL_W-1:0] d2, input logic [EL_W-1:0] d3);
    queue_row(0, d0, 0, 0, 0);
    queue_row(1, 0, d1, 0, 0);
    queue_row(2, 0, 0, d2, 0);
    queue_row(3, 0, 0, 0, d3);
  endfunction

  // Driver: bursts of beats separated by random gaps; valid only drops after a beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid     <= 1'b0;
      in_bus.row_index <= '0;
      in_bus.elem_c0   <= '0;
      in_bus.elem_c1   <= '0;
      in_bus.elem_c2   <= '0;
      in_bus.elem_c3   <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_bus.valid) begin
        absorb_row(pending_rows.pop_front());
        rows_accepted++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pending_rows.size() > 0) begin
        in_bus.valid     <= 1'b1;
        in_bus.row_index <= pending_rows[0].row;
        in_bus.elem_c0   <= pending_rows[0].el[0];
        in_bus.elem_c1   <= pending_rows[0].el[1];
        in_bus.elem_c2   <= pending_rows[0].el[2];
        in_bus.elem_c3   <= pending_rows[0].el[3];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern with always-ready stretches, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left   = 0;
      hold_done   = 1'b0;
      stall_phase = '0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (!hold_done && results_taken >= 60) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_bus.ready <= 1'b0;
    end else begin
      stall_phase++;
      out_bus.ready <= stall_phase[5] ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // Monitor: compare each result beat with the oldest predicted inverse row.
  always @(posedge clk) begin
    inv_row_t want;
    inv_row_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.row      = out_bus.out_row;
      got.res      = {out_bus.res_c3, out_bus.res_c2, out_bus.res_c1, out_bus.res_c0};
      got.singular = out_bus.singular;
      got.last     = out_bus.last_row;
      results_taken++;
      if (got.singular) singular_taken++;
      if (inverse_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: row %0d res %h sing %b last %b",
                   got.row, got.res, got.singular, got.last);
      end else begin
        want = inverse_rows.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp row %0d res %h sing %b last %b / got row %0d res %h sing %b last %b",
                     want.row, want.res, want.singular, want.last,
                     got.row, got.res, got.singular, got.last);
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("matrix4x4_inverse_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    int order [4];
    int tmp;
    int k;
    rst_n = 1'b0;
    rows_accepted  = 0;
    results_taken  = 0;
    singular_taken = 0;
    mismatches     = 0;
    idle_cycles    = 0;
    for (int i = 0; i < 16; i++) shadow_store[i] = '0;

    // Directed: row 3 alone right after reset sees an all-zero store -> singular.
    queue_row(3, 0, 0, 0, 0);
    // Identity.
    queue_diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    // Rows out of order (2, 0, 1, 3) on a sparse matrix.
    queue_row(2, 32'h0002_0000, 0, 0, 32'h0000_8000);
    queue_row(0, 0, 32'hFFFC_0000, 0, 0);
    queue_row(1, 0, 0, 0, 32'h0003_0000);
    queue_row(3, 32'h0000_4000, 0, 32'h0001_0000, 0);
    // Tiny determinant: both saturation ends.
    queue_diag(32'h1, 32'hFFFF_FFFF, 32'h1, 32'h1);
    // Element extremes.
    queue_diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    // Row 3 alone reuses rows left from the previous matrix.
    queue_row(3, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);

    // Random: mostly complete matrices with random content, some stray rows.
    k = 0;
    while (k < 410) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_row($urandom_range(0, 3), $urandom(), $urandom(), $urandom(), $urandom());
        k++;
      end else begin
        kind = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
        for (int i = 0; i < 3; i++) order[i] = i;
        if ($urandom_range(0, 3) == 0) begin
          tmp = $urandom_range(0, 2);
          order[tmp] = order[0];
          order[0] = tmp;
        end
        order[3] = 3;
        for (int i = 0; i < 4; i++)
          queue_row(order[i], pick_elem(kind), pick_elem(kind), pick_elem(kind),
                    pick_elem(kind));
        k += 4;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all rows sent, then all inverse rows taken, then a short settle.
    while (pending_rows.size() > 0 || in_bus.valid) @(posedge clk);
    while (inverse_rows.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d input rows and %0d result rows (%0d singular)",
             rows_accepted, results_taken, singular_taken);
    $display("random phase mixes small, full-range and corner elements; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("matrix4x4_inverse_tb: clean");
    end else begin
      $display("matrix4x4_inverse_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
